[design/cmrw_pkg.sv]
// Shared types, constants and arithmetic helpers of the Catmull-Rom weight block.
package cmrw_pkg;

  // Node table size and derived widths.
  localparam int MaxNodes = 64;
  localparam int NodeAw   = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);

  // Fraction bits of t and the shared divider widths.
  localparam int FracW = 20;
  localparam int DivNw = 62;
  localparam int DivDw = 43;
  localparam int DivCw = $clog2(DivNw + 1);

  typedef enum logic [0:0] {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } cmrw_op_e;

  // One input item after classification by the front.
  typedef struct packed {
    logic        is_query;
    logic        slot_ok;
    logic [5:0]  node_index;
    logic [31:0] node_value;
    logic [31:0] query_x;
  } cmrw_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DivNw-1:0] num;
    logic [DivDw-1:0] den;
  } cmrw_div_req_t;

  typedef enum logic [4:0] {
    StIdle,
    StRdLast,
    StRange,
    StSrch,
    StCmp,
    StRx0,
    StRx1,
    StRxm,
    StRxp,
    StTdiv,
    StSq,
    StCube,
    StHerm,
    StRnd,
    StMulA,
    StDivA,
    StAwait,
    StMulB,
    StDivB,
    StBwait,
    StOut
  } cmrw_state_e;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? (~v + 64'd1) : v;
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // Saturate to a signed 24-bit weight.
  function automatic logic [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'h7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'h800000;
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

[design/cmrw_front.sv]
// Input queue: accepts items, classifies them and buffers two for the back end.
module cmrw_front
  import cmrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [0:0]  opcode_i,
  input  logic [5:0]  node_index_i,
  input  logic [31:0] node_value_i,
  input  logic [31:0] query_x_i,
  output logic        item_valid_o,
  output cmrw_item_t  item_o,
  input  logic        item_take_i
);

  cmrw_item_t  buf_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;
  cmrw_item_t  new_item;

  // Classify the incoming item.
  always_comb begin
    new_item.is_query   = (opcode_i == OpQuery);
    new_item.slot_ok    = (32'(node_index_i) < MaxNodes);
    new_item.node_index = node_index_i;
    new_item.node_value = node_value_i;
    new_item.query_x    = query_x_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign do_push      = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign do_pop       = item_take_i && item_valid_o;
  assign item_o       = buf_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage of buffered items.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[design/cmrw_div.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
module cmrw_div
  import cmrw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmrw_div_req_t    req_i,
  output logic             done_o,
  output logic [DivNw-1:0] quo_o
);

  logic [DivDw:0]   rem_q, rem_d;
  logic [DivNw-1:0] quo_q, quo_d;
  logic [DivDw-1:0] den_q, den_d;
  logic [DivCw-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DivDw:0]   rem_sh;
  logic [DivDw+1:0] diff;

  assign rem_sh = {rem_q[DivDw-1:0], quo_q[DivNw-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_q};

  // One shift-and-subtract step per cycle while the count runs.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = DivCw'(DivNw);
    end else if (cnt_q != '0) begin
      if (!diff[DivDw+1]) begin
        rem_d = diff[DivDw:0];
        quo_d = {quo_q[DivNw-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DivNw-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DivCw'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[design/cmrw_back.sv]
// Back end: node table, interval search, weight arithmetic and result register.
module cmrw_back
  import cmrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        node_count_we_i,
  input  logic [6:0]  node_count_i,
  input  logic        item_valid_i,
  input  cmrw_item_t  item_i,
  output logic        item_take_o,
  output logic        empty,
  input  logic        pop,
  output logic        in_range_o,
  output logic [6:0]  start_offset_o,
  output logic [23:0] weight_0_o,
  output logic [23:0] weight_1_o,
  output logic [23:0] weight_2_o,
  output logic [23:0] weight_3_o
);

  // Control registers.
  cmrw_state_e state_q, state_d;
  logic [6:0]       node_count_q;
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  size_q, size_d;
  logic [CntW-1:0]  idx_q, idx_d;

  // Datapath registers.
  logic signed [31:0] x_q, x_d, xf_q, xf_d;
  logic signed [31:0] x0_q, x0_d, x1_q, x1_d, xm_q, xm_d, xp_q, xp_d;
  logic signed [32:0] width_q, width_d;
  logic        [20:0] t_q, t_d;
  logic        [40:0] t2_q, t2_d;
  logic        [60:0] t3_q, t3_d;
  logic signed [63:0] h00_q, h00_d, h01_q, h01_d, h10_q, h10_d, h11_q, h11_d;
  logic signed [63:0] w1b_q, w1b_d, w2b_q, w2b_d;
  logic signed [63:0] h10s_q, h10s_d, h11s_q, h11s_d;
  logic signed [63:0] prod_q, prod_d, a_q, a_d, b_q, b_d;
  logic               neg_q, neg_d, inr_q, inr_d;

  // Result register.
  logic        out_inr_q, out_inr_d;
  logic [6:0]  out_off_q, out_off_d;
  logic [23:0] out_w0_q, out_w0_d, out_w1_q, out_w1_d, out_w2_q, out_w2_d;
  logic [23:0] out_w3_q, out_w3_d;

  // Node table.
  logic [31:0]       mem_q [MaxNodes];
  logic [31:0]       rd_q;
  logic [NodeAw-1:0] raddr;
  logic              mem_we;

  // Divider link.
  cmrw_div_req_t    div_req;
  logic             div_done;
  logic [DivNw-1:0] div_quo;

  // Helpers.
  logic [CntW-1:0]    n_clamp;
  logic [CntW-1:0]    half;
  logic [CntW-1:0]    mid;
  logic signed [32:0] num_t;
  logic signed [32:0] span;
  logic [32:0]        span_mag;
  logic [DivDw-1:0]   den_s;
  logic [63:0]        prod_mag;
  logic signed [63:0] quo_s;
  logic               first_iv, last_iv, out_free;
  logic signed [63:0] w0, w1, w2, w3;

  cmrw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Clamp the node count to between 2 and the table size.
  always_comb begin
    if (node_count_q < 7'd2) begin
      n_clamp = CntW'(2);
    end else if (32'(node_count_q) > MaxNodes) begin
      n_clamp = CntW'(MaxNodes);
    end else begin
      n_clamp = CntW'(node_count_q);
    end
  end

  assign half     = size_q >> 1;
  assign mid      = lo_q + half;
  assign num_t    = 33'(x_q) - 33'(x0_q);
  assign prod_mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  assign quo_s    = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign first_iv = (idx_q == '0);
  assign last_iv  = ((idx_q + CntW'(2)) >= n_q);
  assign out_free = !out_valid_q || pop;
  assign span_mag = span[32] ? 33'(-span) : 33'(span);
  assign den_s    = {span_mag, 10'b0};

  // Outer span of the left or right width-ratio term.
  always_comb begin
    if (state_q == StDivA) begin
      span = 33'(x1_q) - 33'(xm_q);
    end else begin
      span = 33'(xp_q) - 33'(x0_q);
    end
  end

  // Final weight sums with the one-sided rule at the ends.
  always_comb begin
    w0 = first_iv ? 64'sd0 : -a_q;
    w1 = w1b_q - (first_iv ? a_q : 64'sd0) - b_q;
    w2 = w2b_q + a_q + (last_iv ? b_q : 64'sd0);
    w3 = last_iv ? 64'sd0 : b_q;
  end

  // Sequencer: next state, datapath updates and table addressing.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    n_d = n_q; lo_d = lo_q; size_d = size_q; idx_d = idx_q;
    x_d = x_q; xf_d = xf_q; x0_d = x0_q; x1_d = x1_q; xm_d = xm_q; xp_d = xp_q;
    width_d = width_q; t_d = t_q; t2_d = t2_q; t3_d = t3_q;
    h00_d = h00_q; h01_d = h01_q; h10_d = h10_q; h11_d = h11_q;
    w1b_d = w1b_q; w2b_d = w2b_q; h10s_d = h10s_q; h11s_d = h11s_q;
    prod_d = prod_q; a_d = a_q; b_d = b_q; neg_d = neg_q; inr_d = inr_q;
    out_inr_d = out_inr_q; out_off_d = out_off_q;
    out_w0_d = out_w0_q; out_w1_d = out_w1_q; out_w2_d = out_w2_q; out_w3_d = out_w3_q;
    raddr       = '0;
    mem_we      = 1'b0;
    item_take_o = 1'b0;
    div_req     = '0;

    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          if (item_i.is_query) begin
            x_d     = $signed(item_i.query_x);
            n_d     = n_clamp;
            state_d = StRdLast;
          end else begin
            mem_we = item_i.slot_ok;
          end
        end
      end
      StRdLast: begin
        xf_d    = $signed(rd_q);
        raddr   = NodeAw'(n_q - 1'b1);
        state_d = StRange;
      end
      StRange: begin
        inr_d = (x_q >= xf_q) && (x_q <= $signed(rd_q));
        if ((x_q >= xf_q) && (x_q <= $signed(rd_q))) begin
          lo_d    = CntW'(1);
          size_d  = n_q - CntW'(2);
          state_d = StSrch;
        end else begin
          state_d = StOut;
        end
      end
      StSrch: begin
        if (size_q == '0) begin
          idx_d   = lo_q - 1'b1;
          raddr   = NodeAw'(lo_q - 1'b1);
          state_d = StRx0;
        end else begin
          raddr   = NodeAw'(mid);
          state_d = StCmp;
        end
      end
      StCmp: begin
        if ($signed(rd_q) <= x_q) begin
          lo_d   = mid + 1'b1;
          size_d = size_q - half - 1'b1;
        end else begin
          size_d = half;
        end
        state_d = StSrch;
      end
      StRx0: begin
        x0_d    = $signed(rd_q);
        raddr   = NodeAw'(idx_q + 1'b1);
        state_d = StRx1;
      end
      StRx1: begin
        x1_d    = $signed(rd_q);
        raddr   = NodeAw'(idx_q - 1'b1);
        state_d = StRxm;
      end
      StRxm: begin
        xm_d    = $signed(rd_q);
        raddr   = NodeAw'(idx_q + CntW'(2));
        state_d = StRxp;
      end
      StRxp: begin
        // Interval fraction t, by division unless it is trivially 0 or 1.
        xp_d    = $signed(rd_q);
        width_d = 33'(x1_q) - 33'(x0_q);
        if ((33'(x1_q) - 33'(x0_q)) <= 33'sd0 || num_t <= 33'sd0) begin
          t_d     = '0;
          state_d = StSq;
        end else if (num_t >= (33'(x1_q) - 33'(x0_q))) begin
          t_d     = 21'(1 << FracW);
          state_d = StSq;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = (DivNw'(num_t[31:0]) << FracW)
                        + DivNw'(width_d[32:1]);
          div_req.den   = DivDw'(width_d[31:0]);
          state_d       = StTdiv;
        end
      end
      StTdiv: begin
        if (div_done) begin
          t_d     = 21'(div_quo);
          state_d = StSq;
        end
      end
      StSq: begin
        t2_d    = 41'(t_q * t_q);
        state_d = StCube;
      end
      StCube: begin
        t3_d    = 61'(t2_q * t_q);
        state_d = StHerm;
      end
      StHerm: begin
        // Hermite basis in Q.60.
        h00_d = 2 * $signed(64'(t3_q)) - 3 * $signed(64'(t2_q) << FracW)
              + (64'sd1 <<< 60);
        h01_d = 3 * $signed(64'(t2_q) << FracW) - 2 * $signed(64'(t3_q));
        h10_d = $signed(64'(t3_q)) - 2 * $signed(64'(t2_q) << FracW)
              + $signed(64'(t_q) << (2 * FracW));
        h11_d = $signed(64'(t3_q)) - $signed(64'(t2_q) << FracW);
        state_d = StRnd;
      end
      StRnd: begin
        w1b_d  = rnd_shr(h00_q, 40);
        w2b_d  = rnd_shr(h01_q, 40);
        a_d    = rnd_shr(h10_q, 40);
        b_d    = rnd_shr(h11_q, 40);
        h10s_d = rnd_shr(h10_q, 30);
        h11s_d = rnd_shr(h11_q, 30);
        state_d = StMulA;
      end
      StMulA: begin
        prod_d  = 64'($signed(h10s_q[31:0]) * width_q);
        state_d = StDivA;
      end
      StDivA: begin
        // Left term: width over the span back to the previous node.
        if (first_iv) begin
          state_d = StMulB;
        end else if (span == 33'sd0) begin
          a_d     = 64'sd0;
          state_d = StMulB;
        end else begin
          neg_d         = prod_q[63] ^ span[32];
          div_req.start = 1'b1;
          div_req.num   = DivNw'(prod_mag) + DivNw'(den_s >> 1);
          div_req.den   = den_s;
          state_d       = StAwait;
        end
      end
      StAwait: begin
        if (div_done) begin
          a_d     = quo_s;
          state_d = StMulB;
        end
      end
      StMulB: begin
        prod_d  = 64'($signed(h11s_q[31:0]) * width_q);
        state_d = StDivB;
      end
      StDivB: begin
        // Right term: width over the span to the next-but-one node.
        if (last_iv) begin
          state_d = StOut;
        end else if (span == 33'sd0) begin
          b_d     = 64'sd0;
          state_d = StOut;
        end else begin
          neg_d         = prod_q[63] ^ span[32];
          div_req.start = 1'b1;
          div_req.num   = DivNw'(prod_mag) + DivNw'(den_s >> 1);
          div_req.den   = den_s;
          state_d       = StBwait;
        end
      end
      StBwait: begin
        if (div_done) begin
          b_d     = quo_s;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_inr_d   = inr_q;
          if (inr_q) begin
            out_off_d = 7'(idx_q) - 7'd1;
            out_w0_d  = sat24(w0);
            out_w1_d  = sat24(w1);
            out_w2_d  = sat24(w2);
            out_w3_d  = sat24(w3);
          end else begin
            out_off_d = '0;
            out_w0_d  = '0;
            out_w1_d  = '0;
            out_w2_d  = '0;
            out_w3_d  = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      node_count_q <= 7'd2;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (node_count_we_i) begin
        node_count_q <= node_count_i;
      end
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk_i) begin
    n_q <= n_d; lo_q <= lo_d; size_q <= size_d; idx_q <= idx_d;
    x_q <= x_d; xf_q <= xf_d; x0_q <= x0_d; x1_q <= x1_d; xm_q <= xm_d; xp_q <= xp_d;
    width_q <= width_d; t_q <= t_d; t2_q <= t2_d; t3_q <= t3_d;
    h00_q <= h00_d; h01_q <= h01_d; h10_q <= h10_d; h11_q <= h11_d;
    w1b_q <= w1b_d; w2b_q <= w2b_d; h10s_q <= h10s_d; h11s_q <= h11s_d;
    prod_q <= prod_d; a_q <= a_d; b_q <= b_d; neg_q <= neg_d; inr_q <= inr_d;
    out_inr_q <= out_inr_d; out_off_q <= out_off_d;
    out_w0_q <= out_w0_d; out_w1_q <= out_w1_d; out_w2_q <= out_w2_d; out_w3_q <= out_w3_d;
  end

  // Node table with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[NodeAw'(item_i.node_index)] <= item_i.node_value;
    end
    rd_q <= mem_q[raddr];
  end

  assign empty          = !out_valid_q;
  assign in_range_o     = out_inr_q;
  assign start_offset_o = out_off_q;
  assign weight_0_o     = out_w0_q;
  assign weight_1_o     = out_w1_q;
  assign weight_2_o     = out_w2_q;
  assign weight_3_o     = out_w3_q;

  // Items are taken from the queue only by an idle sequencer.
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |-> (state_q == StIdle))
    else $error("item taken while busy");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && out_free) |-> (!out_valid_q || pop))
    else $error("result overwritten");

  // An out-of-range result carries zero offset and weights.
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_inr_q) |-> (out_off_q == '0 && out_w0_q == '0 &&
      out_w1_q == '0 && out_w2_q == '0 && out_w3_q == '0))
    else $error("out-of-range result not zero");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StTdiv || state_q == StAwait || state_q == StBwait))
    else $error("divider finished outside a wait state");

endmodule

[design/catmull_rom_spline_weights.sv]
// Top level of the Catmull-Rom spline weight generator.
//
// Input channel: an item is taken when push is high and full is low. A load
// item (opcode 0) writes node_value into table slot node_index and yields no
// result. A query item (opcode 1) yields one result: in_range, start_offset
// and four signed Q3.20 weights for query_x.
// Result channel: while empty is low the oldest result is on the outputs;
// it leaves when pop is high. A two-entry queue sits in front of the
// sequencer, so items are still taken while a result waits to be popped.
// A load is handled in the idle state of the sequencer. A query out of range does
// two table reads for the range check and then writes the result.
// A query in range adds up to six binary search steps, four neighbor reads,
// the multiplies and up to three divisions on the shared divider.
// node_count is written through node_count_we_i / node_count_i; reset sets it
// to 2, empties both queues and idles the sequencer. The node table is not
// cleared and must be loaded before queries. If the receiver stalls, the
// finished query holds in the sequencer and the input queue fills up.
module catmull_rom_spline_weights
  import cmrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [0:0]  opcode_i,
  input  logic [5:0]  node_index_i,
  input  logic [31:0] node_value_i,
  input  logic [31:0] query_x_i,
  input  logic        node_count_we_i,
  input  logic [6:0]  node_count_i,
  output logic        empty,
  input  logic        pop,
  output logic        in_range_o,
  output logic [6:0]  start_offset_o,
  output logic [23:0] weight_0_o,
  output logic [23:0] weight_1_o,
  output logic [23:0] weight_2_o,
  output logic [23:0] weight_3_o
);

  logic       item_valid;
  logic       item_take;
  cmrw_item_t item;

  cmrw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .node_index_i (node_index_i),
    .node_value_i (node_value_i),
    .query_x_i    (query_x_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  cmrw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_count_we_i (node_count_we_i),
    .node_count_i    (node_count_i),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_take_o     (item_take),
    .empty           (empty),
    .pop             (pop),
    .in_range_o      (in_range_o),
    .start_offset_o  (start_offset_o),
    .weight_0_o      (weight_0_o),
    .weight_1_o      (weight_1_o),
    .weight_2_o      (weight_2_o),
    .weight_3_o      (weight_3_o)
  );

endmodule

[tb/sv/tb_catmull_rom_spline_weights.sv]
// Self-checking testbench for the Catmull-Rom spline weight generator.
`timescale 1ns / 1ps

module tb_catmull_rom_spline_weights;
  import cmrw_pkg::*;

  // One input item as queued for the driver.
  typedef struct packed {
    cmrw_op_e    op;
    logic [5:0]  node_index;
    logic [31:0] node_value;
    logic [31:0] query_x;
  } spline_item_t;

  // One result item as predicted and as observed.
  typedef struct packed {
    logic        in_range;
    logic [6:0]  start_offset;
    logic [23:0] weight_0;
    logic [23:0] weight_1;
    logic [23:0] weight_2;
    logic [23:0] weight_3;
  } weight_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [0:0]  opcode_i = OpLoad;
  logic [5:0]  node_index_i = '0;
  logic [31:0] node_value_i = '0;
  logic [31:0] query_x_i = '0;
  logic        node_count_we_i = 1'b0;
  logic [6:0]  node_count_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        in_range_o;
  logic [6:0]  start_offset_o;
  logic [23:0] weight_0_o;
  logic [23:0] weight_1_o;
  logic [23:0] weight_2_o;
  logic [23:0] weight_3_o;

  spline_item_t pending_items[$];
  weight_set_t  expected_weights[$];
  int           error_count = 0;
  bit           calm = 1'b0;
  bit           want_stall = 1'b0;
  bit           stall_done = 1'b0;
  int           stall_left = 0;

  // Node table and count as the block holds them, updated on acceptance.
  logic signed [31:0] model_nodes[MaxNodes];
  logic [6:0]         model_count = 7'd2;
  // Node table as planned by the stimulus, used to aim queries.
  logic signed [31:0] plan_nodes[MaxNodes];

  catmull_rom_spline_weights dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .node_value_i   (node_value_i),
    .query_x_i      (query_x_i),
    .node_count_we_i(node_count_we_i),
    .node_count_i   (node_count_i),
    .empty          (empty),
    .pop            (pop),
    .in_range_o     (in_range_o),
    .start_offset_o (start_offset_o),
    .weight_0_o     (weight_0_o),
    .weight_1_o     (weight_1_o),
    .weight_2_o     (weight_2_o),
    .weight_3_o     (weight_3_o)
  );

  always #1 clk_i = ~clk_i;

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q = (mag + longint'(den) / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Basis term times the interval width over the outer span, in Q3.20.
  function automatic longint span_scaled(longint h, longint width, longint span);
    longint h30;
    longint num;
    h30 = round_div(h, 64'sd1 <<< 30);
    num = h30 * width;
    if (span == 0) return 0;
    if (span < 0) begin
      span = -span;
      num = -num;
    end
    return round_div(num, span * 1024);
  endfunction

  function automatic logic [23:0] clip24(longint v);
    if (v > 64'sd8388607) return 24'h7fffff;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic int active_nodes(logic [6:0] cnt);
    if (cnt < 2) return 2;
    if (cnt > MaxNodes) return MaxNodes;
    return cnt;
  endfunction

  // Expected weights for a query at x against the current node table.
  function automatic weight_set_t spline_weights(logic signed [31:0] qx);
    weight_set_t r;
    longint n, x, x0, x1, width, num, t, p1, p2, p3;
    longint h00, h01, h10, h11, a, b, size, first, half, mid, idx;
    longint w[4];
    r = '0;
    n = active_nodes(model_count);
    x = qx;
    if (!(x >= model_nodes[0] && x <= model_nodes[n-1])) return r;
    size = n - 2;
    first = 1;
    while (size > 0) begin
      half = size / 2;
      mid = first + half;
      if (model_nodes[mid] <= x) begin
        first = mid + 1;
        size -= half + 1;
      end else begin
        size = half;
      end
    end
    idx = first - 1;
    if (idx < 0) idx = 0;
    if (idx > n - 2) idx = n - 2;
    x0 = model_nodes[idx];
    x1 = model_nodes[idx+1];
    width = x1 - x0;
    num = x - x0;
    if (width <= 0 || num <= 0) t = 0;
    else if (num >= width) t = 64'sd1 <<< 20;
    else t = round_div(num * (64'sd1 <<< 20), width);
    p3 = t * t * t;
    p2 = t * t * (64'sd1 <<< 20);
    p1 = t * (64'sd1 <<< 40);
    h00 = 2 * p3 - 3 * p2 + (64'sd1 <<< 60);
    h01 = 3 * p2 - 2 * p3;
    h10 = p3 - 2 * p2 + p1;
    h11 = p3 - p2;
    w[1] = round_div(h00, 64'sd1 <<< 40);
    w[2] = round_div(h01, 64'sd1 <<< 40);
    // Left side: outer node or one-sided rule on the first interval.
    if (idx > 0) begin
      a = span_scaled(h10, width, x1 - model_nodes[idx-1]);
      w[0] = -a;
      w[2] += a;
    end else begin
      a = round_div(h10, 64'sd1 <<< 40);
      w[0] = 0;
      w[1] -= a;
      w[2] += a;
    end
    // Right side: outer node or one-sided rule on the last interval.
    if (idx + 2 < n) begin
      b = span_scaled(h11, width, model_nodes[idx+2] - x0);
      w[1] -= b;
      w[3] = b;
    end else begin
      b = round_div(h11, 64'sd1 <<< 40);
      w[1] -= b;
      w[2] += b;
      w[3] = 0;
    end
    r.in_range = 1'b1;
    r.start_offset = 7'(idx - 1);
    r.weight_0 = clip24(w[0]);
    r.weight_1 = clip24(w[1]);
    r.weight_2 = clip24(w[2]);
    r.weight_3 = clip24(w[3]);
    return r;
  endfunction

  // Driver: apply the accepted item to the model, then offer the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        if (pending_items[0].op == OpLoad) begin
          model_nodes[pending_items[0].node_index] = pending_items[0].node_value;
        end else begin
          expected_weights.push_back(spline_weights(pending_items[0].query_x));
        end
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        push <= 1'b1;
        opcode_i <= pending_items[0].op;
        node_index_i <= pending_items[0].node_index;
        node_value_i <= pending_items[0].node_value;
        query_x_i <= pending_items[0].query_x;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver hold-off, counted down in cycles.
  always @(posedge clk_i) begin
    if (want_stall && !stall_done) begin
      stall_left <= 3000;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    weight_set_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_weights.size() == 0) begin
          $display("result item with no query waiting");
          error_count++;
        end else begin
          want = expected_weights.pop_front();
          if (in_range_o !== want.in_range)
            report_mismatch("in_range", in_range_o, want.in_range);
          if (start_offset_o !== want.start_offset)
            report_mismatch("start_offset", start_offset_o, want.start_offset);
          if (weight_0_o !== want.weight_0) report_mismatch("weight_0", weight_0_o, want.weight_0);
          if (weight_1_o !== want.weight_1) report_mismatch("weight_1", weight_1_o, want.weight_1);
          if (weight_2_o !== want.weight_2) report_mismatch("weight_2", weight_2_o, want.weight_2);
          if (weight_3_o !== want.weight_3) report_mismatch("weight_3", weight_3_o, want.weight_3);
        end
      end
      pop <= (stall_left == 0) && (calm || $urandom_range(0, 99) >= 6);
    end
  end

  task automatic add_load(int slot, logic [31:0] value);
    spline_item_t it;
    it.op = OpLoad;
    it.node_index = slot[5:0];
    it.node_value = value;
    it.query_x = $urandom;
    plan_nodes[slot] = value;
    pending_items.push_back(it);
  endtask

  task automatic add_query(logic [31:0] x);
    spline_item_t it;
    it.op = OpQuery;
    it.node_index = $urandom;
    it.node_value = $urandom;
    it.query_x = x;
    pending_items.push_back(it);
  endtask

  // Wait until every item is taken and every result has come back.
  task automatic drain();
    wait (pending_items.size() == 0 && !push && expected_weights.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] value);
    @(posedge clk_i);
    node_count_we_i <= 1'b1;
    node_count_i <= value;
    @(posedge clk_i);
    node_count_we_i <= 1'b0;
    model_count = value;
  endtask

  // Fill the first m nodes: sorted, spread over the full range, or unsorted.
  task automatic fill_nodes(int m, int kind);
    longint v;
    v = $signed($urandom_range(0, 32'h7fffffff)) - 64'sd1073741824;
    for (int i = 0; i < m; i++) begin
      case (kind)
        0: begin
          add_load(i, v[31:0]);
          v += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 22);
        end
        1: add_load(i, 32'(-64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (m - 1)));
        default: add_load(i, $urandom);
      endcase
    end
  endtask

  // A query aimed at the planned table: inside, on a node, outside or anywhere.
  task automatic add_aimed_query(int m);
    int r;
    int i;
    longint lo, hi;
    r = $urandom_range(0, 99);
    i = $urandom_range(0, m - 2);
    lo = plan_nodes[i];
    hi = plan_nodes[i+1];
    if (r < 60) begin
      add_query((hi > lo) ? 32'(lo + ({$urandom, $urandom} % (hi - lo + 1))) : 32'(lo));
    end else if (r < 75) begin
      add_query(plan_nodes[$urandom_range(0, m - 1)]);
    end else if (r < 82) begin
      lo = longint'(plan_nodes[0]) - $urandom_range(1, 1000);
      add_query((lo < -64'sd2147483648) ? 32'h80000000 : 32'(lo));
    end else if (r < 89) begin
      hi = longint'(plan_nodes[m-1]) + $urandom_range(1, 1000);
      add_query((hi > 64'sd2147483647) ? 32'h7fffffff : 32'(hi));
    end else begin
      add_query($urandom);
    end
  endtask

  initial begin
    logic [6:0] counts[12] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd5, 7'd33, 7'd17,
                               7'd64, 7'd3, 7'd48, 7'd9, 7'd2};
    int m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every slot written once so no read ever finds an unwritten node.
    fill_nodes(MaxNodes, 0);
    drain();

    // Directed: four nodes spanning the full range, then duplicated nodes.
    write_count(7'd4);
    fill_nodes(4, 1);
    add_query(32'h80000000);
    add_query(32'h7fffffff);
    add_query(plan_nodes[1]);
    add_query(plan_nodes[2]);
    add_query(32'h00000000);
    add_query(32'(longint'(plan_nodes[1]) + 1));
    add_query(32'(longint'(plan_nodes[2]) - 1));
    // Zero-width intervals and a zero outer span.
    add_load(0, 32'h00010000);
    add_load(1, 32'h00010000);
    add_load(2, 32'h00010000);
    add_load(3, 32'h00030000);
    add_query(32'h00010000);
    add_query(32'h00018000);
    add_query(32'h00030000);
    add_query(32'h0000ffff);
    add_query(32'h00030001);
    drain();

    // Random phases over several node counts and table shapes.
    for (int p = 0; p < 12; p++) begin
      write_count(counts[p]);
      m = active_nodes(counts[p]);
      calm = (p == 5);
      if (p == 3) want_stall = 1'b1;
      fill_nodes(m, (p % 4 == 3) ? 2 : (p % 4 == 1) ? 1 : 0);
      for (int k = 0; k < 63; k++) begin
        if ($urandom_range(0, 9) == 0) add_load($urandom_range(0, m - 1), $urandom);
        else add_aimed_query(m);
      end
      drain();
    end
    calm = 1'b0;

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[catmull_rom_spline_weights.f]
design/cmrw_pkg.sv
design/cmrw_front.sv
design/cmrw_div.sv
design/cmrw_back.sv
design/catmull_rom_spline_weights.sv
tb/sv/tb_catmull_rom_spline_weights.sv
